// ===== hw/rtl/sorm_pkg.sv =====
// Shared constants and register codes for the second-order response magnitude block.
package sorm_pkg;

    localparam int COEF_WIDTH     = 32;
    localparam int FREQ_FRAC_BITS = 16;
    localparam int COEF_FRAC      = 24;
    localparam int FREQ_WIDTH     = FREQ_FRAC_BITS + 1;
    localparam int W2_WIDTH       = 2 * FREQ_WIDTH - FREQ_FRAC_BITS;
    localparam int PROD_WIDTH     = COEF_WIDTH + W2_WIDTH;
    localparam int TERM_WIDTH     = PROD_WIDTH - FREQ_FRAC_BITS;
    localparam int PART_WIDTH     = TERM_WIDTH + 2;
    localparam int MAG_WIDTH      = PART_WIDTH - 1;
    localparam int SQ_WIDTH       = 2 * MAG_WIDTH;
    localparam int SUM_WIDTH      = SQ_WIDTH + 1;
    localparam int QUO_WIDTH      = 64;
    localparam int ROOT_WIDTH     = 32;
    localparam int FLOOR_WIDTH    = 32;
    localparam int CFG_IDX_WIDTH  = 3;
    localparam int S_TDATA_WIDTH  = ((FREQ_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_WIDTH  = 32;
    localparam int M_TUSER_WIDTH  = 2;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_NUM_CONST  = 3'd0,
        REG_NUM_LINEAR = 3'd1,
        REG_NUM_SQUARE = 3'd2,
        REG_DEN_LINEAR = 3'd3,
        REG_DEN_SQUARE = 3'd4,
        REG_DEN_FLOOR  = 3'd5
    } cfg_reg_t;

endpackage

// ===== hw/rtl/second_order_response_magnitude_top.sv =====
// Top level of the second-order response magnitude pipeline.
//
//  Channel  Direction  Handshake            Payload
//  s_       in         s_tvalid / s_tready  s_tdata[16:0] freq_fraction
//  m_       out        m_tvalid / m_tready  m_tdata magnitude, m_tuser {saturated, zero_den}
//  cfg_     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One request enters per cycle while the output slot can take a result; the
// depth is set by the 64 restoring-division stages and 32 square-root stages.
// Reset (aresetn low, synchronous) clears every valid bit and loads the
// register defaults. When the output register holds a result that is not
// taken, the whole pipeline freezes; nothing is dropped or repeated.
module second_order_response_magnitude_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [sorm_pkg::S_TDATA_WIDTH-1:0]  s_tdata,   // [16:0] freq_fraction
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [sorm_pkg::M_TDATA_WIDTH-1:0]  m_tdata,   // [31:0] magnitude
    output logic [sorm_pkg::M_TUSER_WIDTH-1:0]  m_tuser,   // [0] zero_denominator, [1] saturated
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sorm_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
    input  logic [31:0]                         cfg_data
);
    import sorm_pkg::*;

    localparam int DIV_STAGES  = QUO_WIDTH;
    localparam int SQRT_STAGES = ROOT_WIDTH;
    localparam int LOW_BITS    = 32;

    // Configuration registers.
    logic signed [COEF_WIDTH-1:0] num_const_reg, num_linear_reg, num_square_reg;
    logic signed [COEF_WIDTH-1:0] den_linear_reg, den_square_reg;
    logic [FLOOR_WIDTH-1:0]       den_floor_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_const_reg  <= COEF_WIDTH'(1) <<< COEF_FRAC;
            num_linear_reg <= '0;
            num_square_reg <= '0;
            den_linear_reg <= '0;
            den_square_reg <= '0;
            den_floor_reg  <= FLOOR_WIDTH'(1);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_NUM_CONST:  num_const_reg  <= cfg_data[COEF_WIDTH-1:0];
                REG_NUM_LINEAR: num_linear_reg <= cfg_data[COEF_WIDTH-1:0];
                REG_NUM_SQUARE: num_square_reg <= cfg_data[COEF_WIDTH-1:0];
                REG_DEN_LINEAR: den_linear_reg <= cfg_data[COEF_WIDTH-1:0];
                REG_DEN_SQUARE: den_square_reg <= cfg_data[COEF_WIDTH-1:0];
                REG_DEN_FLOOR:  den_floor_reg  <= cfg_data[FLOOR_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // Global advance: the pipeline moves whenever the output slot can take a result.
    logic m_tvalid_reg;
    logic advance;
    assign advance  = !m_tvalid_reg || m_tready;
    assign s_tready = advance;

    // Magnitude of a signed coefficient, one bit wider than needed is not required.
    function automatic logic [COEF_WIDTH-1:0] coef_mag(input logic signed [COEF_WIDTH-1:0] c);
        coef_mag = c[COEF_WIDTH-1] ? COEF_WIDTH'(-c) : COEF_WIDTH'(c);
    endfunction

    // Stage 1: square the frequency.
    logic                  v1_reg;
    logic [FREQ_WIDTH-1:0] u1_reg;
    logic [W2_WIDTH-1:0]   w2_1_reg;
    logic [FREQ_WIDTH-1:0] u_in;
    logic [2*FREQ_WIDTH-1:0] u_sq;
    assign u_in = s_tdata[FREQ_WIDTH-1:0];
    assign u_sq = (2*FREQ_WIDTH)'(u_in) * (2*FREQ_WIDTH)'(u_in);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (advance) begin
            v1_reg <= s_tvalid;
        end
    end
    always_ff @(posedge aclk) begin
        if (advance) begin
            u1_reg   <= u_in;
            w2_1_reg <= u_sq[2*FREQ_WIDTH-1:FREQ_FRAC_BITS];
        end
    end

    // Stage 2: coefficient magnitudes times frequency terms.
    logic                  v2_reg;
    logic [PROD_WIDTH-1:0] p_nsq_reg, p_nlin_reg, p_dsq_reg, p_dlin_reg;
    logic                  s_nsq_reg, s_nlin_reg, s_dsq_reg, s_dlin_reg;
    logic [W2_WIDTH-1:0]   u1_ext;
    assign u1_ext = W2_WIDTH'(u1_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (advance) begin
            v2_reg <= v1_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (advance) begin
            p_nsq_reg  <= PROD_WIDTH'(coef_mag(num_square_reg)) * PROD_WIDTH'(w2_1_reg);
            p_nlin_reg <= PROD_WIDTH'(coef_mag(num_linear_reg)) * PROD_WIDTH'(u1_ext);
            p_dsq_reg  <= PROD_WIDTH'(coef_mag(den_square_reg)) * PROD_WIDTH'(w2_1_reg);
            p_dlin_reg <= PROD_WIDTH'(coef_mag(den_linear_reg)) * PROD_WIDTH'(u1_ext);
            s_nsq_reg  <= num_square_reg[COEF_WIDTH-1];
            s_nlin_reg <= num_linear_reg[COEF_WIDTH-1];
            s_dsq_reg  <= den_square_reg[COEF_WIDTH-1];
            s_dlin_reg <= den_linear_reg[COEF_WIDTH-1];
        end
    end

    // Stage 3: real and imaginary parts, kept as magnitudes.
    logic signed [PART_WIDTH-1:0] t_nsq, t_nlin, t_dsq, t_dlin, nr, ni, dr, di;
    logic                         v3_reg;
    logic [MAG_WIDTH-1:0]         m_nr_reg, m_ni_reg, m_dr_reg, m_di_reg;

    function automatic logic signed [PART_WIDTH-1:0] signed_term(
        input logic [PROD_WIDTH-1:0] p, input logic neg);
        logic signed [PART_WIDTH-1:0] t;
        t = $signed({2'b00, p[PROD_WIDTH-1:FREQ_FRAC_BITS]});
        signed_term = neg ? -t : t;
    endfunction

    function automatic logic [MAG_WIDTH-1:0] part_mag(input logic signed [PART_WIDTH-1:0] x);
        logic signed [PART_WIDTH-1:0] a;
        a = x[PART_WIDTH-1] ? -x : x;
        part_mag = a[MAG_WIDTH-1:0];
    endfunction

    assign t_nsq  = signed_term(p_nsq_reg, s_nsq_reg);
    assign t_nlin = signed_term(p_nlin_reg, s_nlin_reg);
    assign t_dsq  = signed_term(p_dsq_reg, s_dsq_reg);
    assign t_dlin = signed_term(p_dlin_reg, s_dlin_reg);
    assign nr = PART_WIDTH'(num_const_reg) - t_nsq;
    assign ni = t_nlin;
    assign dr = (PART_WIDTH'(1) <<< COEF_FRAC) - t_dsq;
    assign di = t_dlin;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (advance) begin
            v3_reg <= v2_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (advance) begin
            m_nr_reg <= part_mag(nr);
            m_ni_reg <= part_mag(ni);
            m_dr_reg <= part_mag(dr);
            m_di_reg <= part_mag(di);
        end
    end

    // Stage 4: squares.
    logic                v4_reg;
    logic [SQ_WIDTH-1:0] sq_nr_reg, sq_ni_reg, sq_dr_reg, sq_di_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (advance) begin
            v4_reg <= v3_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (advance) begin
            sq_nr_reg <= SQ_WIDTH'(m_nr_reg) * SQ_WIDTH'(m_nr_reg);
            sq_ni_reg <= SQ_WIDTH'(m_ni_reg) * SQ_WIDTH'(m_ni_reg);
            sq_dr_reg <= SQ_WIDTH'(m_dr_reg) * SQ_WIDTH'(m_dr_reg);
            sq_di_reg <= SQ_WIDTH'(m_di_reg) * SQ_WIDTH'(m_di_reg);
        end
    end

    // Stage 5: squared magnitudes of numerator and denominator.
    logic                 v5_reg;
    logic [SUM_WIDTH-1:0] num_reg, den_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (advance) begin
            v5_reg <= v4_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (advance) begin
            num_reg <= SUM_WIDTH'(sq_nr_reg) + SUM_WIDTH'(sq_ni_reg);
            den_reg <= SUM_WIDTH'(sq_dr_reg) + SUM_WIDTH'(sq_di_reg);
        end
    end

    // Stage 6: floor and overflow checks, division set-up.
    // The quotient overflows exactly when N >= D * 2^32.
    localparam int CMP_WIDTH = SUM_WIDTH + LOW_BITS;
    localparam int REM_WIDTH = SUM_WIDTH;
    logic [CMP_WIDTH-1:0] floor_ext, den_shift, num_ext;
    assign floor_ext = CMP_WIDTH'({den_floor_reg, 32'd0});
    assign den_shift = {den_reg, {LOW_BITS{1'b0}}};
    assign num_ext   = CMP_WIDTH'(num_reg);

    logic                 dv_reg   [0:DIV_STAGES];
    logic                 dz_reg   [0:DIV_STAGES];
    logic                 dov_reg  [0:DIV_STAGES];
    logic [REM_WIDTH-1:0] drem_reg [0:DIV_STAGES];
    logic [REM_WIDTH-1:0] dden_reg [0:DIV_STAGES];
    logic [LOW_BITS-1:0]  dlow_reg [0:DIV_STAGES];
    logic [QUO_WIDTH-1:0] dq_reg   [0:DIV_STAGES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_reg[0] <= 1'b0;
        end else if (advance) begin
            dv_reg[0] <= v5_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (advance) begin
            dz_reg[0]   <= CMP_WIDTH'(den_reg) <= floor_ext;
            dov_reg[0]  <= num_ext >= den_shift;
            drem_reg[0] <= REM_WIDTH'(num_reg[SUM_WIDTH-1:LOW_BITS]);
            dden_reg[0] <= den_reg;
            dlow_reg[0] <= num_reg[LOW_BITS-1:0];
            dq_reg[0]   <= '0;
        end
    end

    // Restoring division, one quotient bit per stage.
    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
        logic [REM_WIDTH:0]   trial;
        logic                 fits;
        logic [REM_WIDTH:0]   diff;
        assign trial = {drem_reg[k], dlow_reg[k][LOW_BITS-1]};
        assign fits  = trial >= {1'b0, dden_reg[k]};
        assign diff  = trial - {1'b0, dden_reg[k]};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_reg[k+1] <= 1'b0;
            end else if (advance) begin
                dv_reg[k+1] <= dv_reg[k];
            end
        end
        always_ff @(posedge aclk) begin
            if (advance) begin
                dz_reg[k+1]   <= dz_reg[k];
                dov_reg[k+1]  <= dov_reg[k];
                dden_reg[k+1] <= dden_reg[k];
                dlow_reg[k+1] <= {dlow_reg[k][LOW_BITS-2:0], 1'b0};
                drem_reg[k+1] <= fits ? diff[REM_WIDTH-1:0] : trial[REM_WIDTH-1:0];
                dq_reg[k+1]   <= {dq_reg[k][QUO_WIDTH-2:0], fits};
            end
        end
    end

    // Digit-by-digit square root, one root bit per stage.
    localparam int SREM_WIDTH = ROOT_WIDTH + 2;
    logic                  rv_reg   [0:SQRT_STAGES];
    logic                  rz_reg   [0:SQRT_STAGES];
    logic                  rov_reg  [0:SQRT_STAGES];
    logic [QUO_WIDTH-1:0]  rq_reg   [0:SQRT_STAGES];
    logic [SREM_WIDTH-1:0] rrem_reg [0:SQRT_STAGES];
    logic [ROOT_WIDTH-1:0] rroot_reg[0:SQRT_STAGES];

    always_comb begin
        rv_reg[0]    = dv_reg[DIV_STAGES];
        rz_reg[0]    = dz_reg[DIV_STAGES];
        rov_reg[0]   = dov_reg[DIV_STAGES];
        rq_reg[0]    = dq_reg[DIV_STAGES];
        rrem_reg[0]  = '0;
        rroot_reg[0] = '0;
    end

    for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_sqrt
        logic [SREM_WIDTH+1:0] trial;
        logic [SREM_WIDTH+1:0] test;
        logic                  fits;
        logic [SREM_WIDTH+1:0] diff;
        assign trial = {rrem_reg[j], rq_reg[j][QUO_WIDTH-1 -: 2]};
        assign test  = (SREM_WIDTH + 2)'({rroot_reg[j], 2'b01});
        assign fits  = trial >= test;
        assign diff  = trial - test;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                rv_reg[j+1] <= 1'b0;
            end else if (advance) begin
                rv_reg[j+1] <= rv_reg[j];
            end
        end
        always_ff @(posedge aclk) begin
            if (advance) begin
                rz_reg[j+1]    <= rz_reg[j];
                rov_reg[j+1]   <= rov_reg[j];
                rq_reg[j+1]    <= {rq_reg[j][QUO_WIDTH-3:0], 2'b00};
                rrem_reg[j+1]  <= fits ? diff[SREM_WIDTH-1:0] : trial[SREM_WIDTH-1:0];
                rroot_reg[j+1] <= {rroot_reg[j][ROOT_WIDTH-2:0], fits};
            end
        end
    end

    // Output register.
    logic [M_TDATA_WIDTH-1:0] m_tdata_reg;
    logic [M_TUSER_WIDTH-1:0] m_tuser_reg;
    logic                     out_zero, out_sat;
    assign out_zero = rz_reg[SQRT_STAGES];
    assign out_sat  = !out_zero && rov_reg[SQRT_STAGES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (advance) begin
            m_tvalid_reg <= rv_reg[SQRT_STAGES];
        end
    end
    always_ff @(posedge aclk) begin
        if (advance) begin
            if (out_zero) begin
                m_tdata_reg <= '0;
            end else if (out_sat) begin
                m_tdata_reg <= '1;
            end else begin
                m_tdata_reg <= rroot_reg[SQRT_STAGES];
            end
            m_tuser_reg <= {out_sat, out_zero};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== hw/rtl/sorm_checker.sv =====
// Port-level checks for the second-order response magnitude block and their binding.
module sorm_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [sorm_pkg::M_TDATA_WIDTH-1:0]  m_tdata,
    input logic [sorm_pkg::M_TUSER_WIDTH-1:0]  m_tuser,
    input logic                                cfg_ready
);
    import sorm_pkg::*;

    // A result held back by the consumer stays on the port.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // An empty output slot never blocks new requests.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // A floored denominator gives zero and no saturation.
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0 && !m_tuser[1])
        else $error("zero denominator result malformed");

    // Saturation shows the full-scale code.
    a_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tdata == '1)
        else $error("saturated result not full scale");

    a_cfg: assert property (@(posedge aclk) disable iff (!aresetn) cfg_ready)
        else $error("configuration port not ready");

endmodule

bind second_order_response_magnitude_top sorm_checker u_sorm_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_ready (cfg_ready)
);

// ===== verif/second_order_response_magnitude_top_tb.sv =====
// Self-checking testbench for the second-order response magnitude block.
`timescale 1ns / 1ps

module second_order_response_magnitude_top_tb;
    import sorm_pkg::*;

    localparam int LATENCY     = 103;
    localparam int CYCLE_LIMIT = 1000000;
    // Register indexes past the last register; writes to them must be ignored.
    localparam logic [CFG_IDX_WIDTH-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [31:0] magnitude;
        logic        zero_den;
        logic        saturated;
    } gain_t;

    logic                     aclk;
    logic                     aresetn;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [S_TDATA_WIDTH-1:0] s_tdata;
    logic                     m_tvalid;
    logic                     m_tready;
    logic [M_TDATA_WIDTH-1:0] m_tdata;
    logic [M_TUSER_WIDTH-1:0] m_tuser;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_WIDTH-1:0] cfg_index;
    logic [31:0]              cfg_data;

    // Shadow copy of the coefficient registers, indexed by register code.
    logic [31:0] coef_shadow [6];
    gain_t       gain_queue [$];
    int          requests_taken;
    int          writes_taken;
    int          fail_count;
    int          cycle_count;
    int          sink_hold;
    bit          idle_enable;

    second_order_response_magnitude_top dut (.*);

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Product of a signed coefficient with a frequency term, magnitude
    // truncated toward zero after dropping the fraction bits of the frequency.
    function automatic logic signed [63:0] scaled_term(logic [31:0] coef, logic [18:0] w);
        logic signed [63:0] c;
        logic [63:0]        m;
        logic [63:0]        p;
        c = $signed(coef);
        m = (c < 0) ? -c : c;
        p = (m * 64'(w)) >> FREQ_FRAC_BITS;
        return (c < 0) ? -$signed(p) : $signed(p);
    endfunction

    function automatic logic [127:0] mag_squared(logic signed [63:0] x);
        logic [127:0] m;
        m = (x < 0) ? 128'(-x) : 128'(x);
        return m * m;
    endfunction

    function automatic logic [31:0] int_root(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = '0;
        b = 64'h1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r[31:0];
    endfunction

    function automatic gain_t predict_gain(logic [FREQ_WIDTH-1:0] u);
        logic [18:0]        w2;
        logic [33:0]        uu;
        logic signed [63:0] nr, ni, dr, di;
        logic [127:0]       num, den, quo;
        gain_t              g;
        uu = 34'(u) * 34'(u);
        w2 = 19'(uu >> FREQ_FRAC_BITS);
        nr = $signed(64'($signed(coef_shadow[REG_NUM_CONST])))
             - scaled_term(coef_shadow[REG_NUM_SQUARE], w2);
        ni = scaled_term(coef_shadow[REG_NUM_LINEAR], 19'(u));
        dr = (64'sd1 <<< COEF_FRAC) - scaled_term(coef_shadow[REG_DEN_SQUARE], w2);
        di = scaled_term(coef_shadow[REG_DEN_LINEAR], 19'(u));
        num = mag_squared(nr) + mag_squared(ni);
        den = mag_squared(dr) + mag_squared(di);
        g = '0;
        if ((128'(coef_shadow[REG_DEN_FLOOR]) << 32) >= den) begin
            g.zero_den = 1'b1;
        end else begin
            quo = (num << 32) / den;
            if (quo[127:64] != 0) begin
                g.magnitude = 32'hFFFF_FFFF;
                g.saturated = 1'b1;
            end else begin
                g.magnitude = int_root(quo[63:0]);
            end
        end
        return g;
    endfunction

    // Everything that happens at a rising edge: accepted requests are predicted,
    // accepted results are checked, register writes update the shadow copy.
    always @(posedge aclk) begin
        gain_t exp_g;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index <= REG_DEN_FLOOR) coef_shadow[cfg_index] = cfg_data;
                writes_taken <= writes_taken + 1;
            end
            if (s_tvalid && s_tready) begin
                gain_queue.push_back(predict_gain(s_tdata[FREQ_WIDTH-1:0]));
                requests_taken <= requests_taken + 1;
            end
            if (m_tvalid && m_tready) begin
                if (gain_queue.size() == 0) begin
                    $error("result with no request outstanding: magnitude %h", m_tdata);
                    fail_count++;
                end else begin
                    exp_g = gain_queue.pop_front();
                    if (m_tdata !== exp_g.magnitude) begin
                        $error("magnitude: expected %h, got %h", exp_g.magnitude, m_tdata);
                        fail_count++;
                    end
                    if (m_tuser[0] !== exp_g.zero_den) begin
                        $error("zero_denominator: expected %b, got %b",
                               exp_g.zero_den, m_tuser[0]);
                        fail_count++;
                    end
                    if (m_tuser[1] !== exp_g.saturated) begin
                        $error("saturated: expected %b, got %b", exp_g.saturated, m_tuser[1]);
                        fail_count++;
                    end
                end
            end
        end
    end

    function automatic int gap_cycles();
        int r;
        if (!idle_enable) return 0;
        r = $urandom_range(0, 19);
        if (r < 12) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side: a long hold-off when asked for, otherwise random stalls while idle_enable is set.
    always @(negedge aclk) begin
        if (sink_hold > 0) begin
            m_tready = 1'b0;
            sink_hold--;
        end else begin
            m_tready = (gap_cycles() == 0);
        end
    end

    task automatic idle_cycles(int n);
        repeat (n) @(negedge aclk);
    endtask

    // Offer one frequency request and wait until it is taken.
    task automatic send_freq(logic [FREQ_WIDTH-1:0] u);
        int start;
        int gap;
        gap = gap_cycles();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            idle_cycles(gap);
        end
        start = requests_taken;
        s_tvalid = 1'b1;
        s_tdata  = S_TDATA_WIDTH'(u);
        do @(negedge aclk); while (requests_taken == start);
        s_tvalid = 1'b0;
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (gain_queue.size() != 0) @(negedge aclk);
        idle_cycles(LATENCY + 8);
    endtask

    task automatic write_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [31:0] value);
        int start;
        start = writes_taken;
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(negedge aclk); while (writes_taken == start);
        cfg_valid = 1'b0;
    endtask

    task automatic load_coefs(logic [31:0] b0, b1, b2, a1, a2, fl);
        wait_drained();
        write_reg(REG_NUM_CONST, b0);
        write_reg(REG_NUM_LINEAR, b1);
        write_reg(REG_NUM_SQUARE, b2);
        write_reg(REG_DEN_LINEAR, a1);
        write_reg(REG_DEN_SQUARE, a2);
        write_reg(REG_DEN_FLOOR, fl);
    endtask

    function automatic logic [FREQ_WIDTH-1:0] rand_freq();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 17'h10000;
            2: return 17'h1FFFF;
            3: return 17'($urandom_range(0, 255));
            default: return 17'($urandom_range(0, 131071));
        endcase
    endfunction

    function automatic logic [31:0] rand_coef();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3: return 32'($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
            4: return 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] rand_floor();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom();
            default: return 32'($urandom_range(0, 4096));
        endcase
    endfunction

    // The reset values give unity gain at every frequency.
    task automatic test_reset_defaults();
        send_freq(17'h0);
        send_freq(17'h10000);
        send_freq(17'h1FFFF);
        send_freq(17'h00001);
        send_freq(17'h0AAAA);
        send_freq(17'h15555);
    endtask

    task automatic test_special_cases();
        // The denominator vanishes at full scale when a2 is 1.0.
        load_coefs(32'h0100_0000, 0, 0, 0, 32'h0100_0000, 32'h1);
        send_freq(17'h10000);
        send_freq(17'h08000);
        // Huge numerator over a tiny denominator saturates the gain.
        load_coefs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h0100_0000, 32'h0);
        send_freq(17'h10000);
        send_freq(17'h0FFFF);
        send_freq(17'h1FFFF);
        // Floor at its maximum swallows almost everything.
        load_coefs(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_freq(17'h0);
        send_freq(17'h1FFFF);
        send_freq(17'h00100);
        // Writes to indexes past the register file must change nothing.
        wait_drained();
        write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
        write_reg(REG_SPARE_HI, 32'h0);
        send_freq(17'h0);
        send_freq(17'h10000);
    endtask

    task automatic test_random_sweeps();
        for (int phase = 0; phase < 8; phase++) begin
            load_coefs(rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                       rand_floor());
            idle_enable = (phase % 3) != 2;
            for (int i = 0; i < 115; i++) send_freq(rand_freq());
        end
        idle_enable = 1'b1;
    endtask

    // The result side holds off long enough to fill the pipeline and stall its
    // input; afterwards the sender pauses until every result is back.
    task automatic test_backpressure();
        load_coefs(32'h0100_0000, 32'h0080_0000, 32'h0010_0000, 32'h0200_0000,
                   32'h0100_0000, 32'h10);
        idle_enable = 1'b0;
        sink_hold   = 400;
        for (int i = 0; i < 200; i++) send_freq(rand_freq());
        idle_enable = 1'b1;
        while (gain_queue.size() != 0) @(negedge aclk);
        for (int i = 0; i < 60; i++) send_freq(rand_freq());
    endtask

    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = REG_NUM_CONST;
        cfg_data       = '0;
        requests_taken = 0;
        writes_taken   = 0;
        fail_count     = 0;
        cycle_count    = 0;
        sink_hold      = 0;
        idle_enable    = 1'b1;
        coef_shadow[REG_NUM_CONST]  = 32'h0100_0000;
        coef_shadow[REG_NUM_LINEAR] = 32'h0;
        coef_shadow[REG_NUM_SQUARE] = 32'h0;
        coef_shadow[REG_DEN_LINEAR] = 32'h0;
        coef_shadow[REG_DEN_SQUARE] = 32'h0;
        coef_shadow[REG_DEN_FLOOR]  = 32'h1;
        idle_cycles(12);
        aresetn = 1'b1;

        test_reset_defaults();
        test_special_cases();
        test_random_sweeps();
        test_backpressure();

        wait_drained();
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
